@@ sv/fit_strategy_block_allocator_top_defines.svh @@
// Assertion macros used by the allocator controller.
`ifndef FIT_STRATEGY_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define FIT_STRATEGY_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

// Implication checked on every rising edge outside reset.
`define FSBA_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define FSBA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/fsba_pkg.sv @@
// Package: payload structs, codes and controller/datapath command types.
package fsba_pkg;

    localparam int OFF_W   = 16;
    localparam int SIZE_W  = 16;
    localparam int CNT_W   = 6;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FIT   = 2'd1;
    localparam logic [1:0] ST_NOT_FND  = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic [1:0] STRAT_FIRST = 2'd0;
    localparam logic [1:0] STRAT_BEST  = 2'd1;
    localparam logic [1:0] STRAT_WORST = 2'd2;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic CFG_STRATEGY = 1'b0;
    localparam logic CFG_CAPACITY = 1'b1;

    typedef struct packed {
        logic              func;
        logic [SIZE_W-1:0] req_size;
        logic [OFF_W-1:0]  release_offset;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [OFF_W-1:0]  granted_offset;
        logic [CNT_W-1:0]  live_count;
        logic [SIZE_W-1:0] used_units;
        logic [SIZE_W-1:0] spare_units;
    } rsp_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic init;      // reinitialise lists
        logic load;      // latch request, reset scan
        logic scan;      // examine one entry
        logic commit;    // apply update, finish result
        logic fail;      // finish result with status
        logic [1:0] fail_status;
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic scan_done;
        logic found;
        logic busy_move;
        logic size_zero;
        logic held_full;
        logic free_full;
    } sts_t;

endpackage

@@ sv/fsba_datapath.sv @@
// Datapath: segment lists, scan unit and shifting list update.
module fsba_datapath #(
    parameter int MAX_SEGMENTS = 32,
    parameter int OFFSET_BITS  = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  fsba_pkg::cmd_t       cmd,
    output fsba_pkg::sts_t       sts,
    input  fsba_pkg::req_t       req,
    input  logic [1:0]           strategy,
    input  logic [15:0]          capacity,
    output fsba_pkg::rsp_t       rsp
);
    import fsba_pkg::*;

    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);

    typedef enum logic {MV_IDLE, MV_PUSH} mv_t;

    // Lists as shift registers: every entry is read at its own place.
    logic [OFFSET_BITS-1:0] fs_reg [MAX_SEGMENTS];
    logic [15:0]            fl_reg [MAX_SEGMENTS];
    logic [OFFSET_BITS-1:0] hs_reg [MAX_SEGMENTS];
    logic [15:0]            hl_reg [MAX_SEGMENTS];
    logic [CW-1:0]          fcnt_reg, hcnt_reg;
    logic [15:0]            total_reg;

    logic                   func_reg;
    logic [15:0]            size_reg;
    logic [OFFSET_BITS-1:0] off_reg;
    logic [CW-1:0]          idx_reg;
    logic [IW-1:0]          pick_reg;
    logic                   found_reg, stop_reg;
    logic [OFFSET_BITS-1:0] ps_reg;
    logic [15:0]            pl_reg;
    mv_t                    phase_reg;

    logic [15:0]            cur_l, pick_l;
    logic                   cur_hit, take;
    logic                   in_range;

    always_comb begin
        in_range = (idx_reg < fcnt_reg) && !stop_reg;
        cur_l    = fl_reg[idx_reg[IW-1:0]];
        pick_l   = fl_reg[pick_reg];
        cur_hit  = 1'b0;
        take     = 1'b0;
        if (func_reg == FUNC_ALLOC) begin
            in_range = (idx_reg < fcnt_reg) && !stop_reg;
            cur_hit  = cur_l >= size_reg;
            case (strategy)
                STRAT_BEST:  take = cur_hit && (!found_reg || cur_l < pick_l);
                STRAT_WORST: take = cur_hit && (!found_reg || cur_l > pick_l);
                default:     take = cur_hit;
            endcase
        end else begin
            in_range = (idx_reg < hcnt_reg) && !stop_reg;
            take     = hs_reg[idx_reg[IW-1:0]] == off_reg;
        end
    end

    always_comb begin
        sts.scan_done = !in_range;
        sts.found     = found_reg;
        sts.busy_move = phase_reg != MV_IDLE;
        sts.size_zero = size_reg == 16'd0;
        sts.held_full = hcnt_reg >= CW'(MAX_SEGMENTS);
        sts.free_full = fcnt_reg >= CW'(MAX_SEGMENTS);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fcnt_reg  <= CW'(1);
            hcnt_reg  <= '0;
            total_reg <= '0;
            phase_reg <= MV_IDLE;
            fs_reg[0] <= '0;
            fl_reg[0] <= 16'hFFFF;
        end else if (cmd.init) begin
            fcnt_reg  <= CW'(1);
            hcnt_reg  <= '0;
            total_reg <= '0;
            fs_reg[0] <= '0;
            fl_reg[0] <= capacity;
        end else begin
            if (cmd.load) begin
                func_reg  <= req.func;
                size_reg  <= req.req_size;
                off_reg   <= OFFSET_BITS'(req.release_offset);
                idx_reg   <= '0;
                pick_reg  <= '0;
                found_reg <= 1'b0;
                stop_reg  <= 1'b0;
            end
            if (cmd.scan && in_range) begin
                idx_reg <= idx_reg + CW'(1);
                if (take) begin
                    pick_reg  <= idx_reg[IW-1:0];
                    found_reg <= 1'b1;
                    if (func_reg == FUNC_FREE || strategy == STRAT_FIRST ||
                        strategy == 2'd3)
                        stop_reg <= 1'b1;
                end
            end
            if (cmd.commit) begin
                // Phase 1: remove picked entry, recording it.
                if (func_reg == FUNC_ALLOC) begin
                    ps_reg <= fs_reg[pick_reg];
                    pl_reg <= fl_reg[pick_reg];
                    for (int i = 0; i < MAX_SEGMENTS - 1; i++) begin
                        if (i >= int'(pick_reg)) begin
                            fs_reg[i] <= fs_reg[i+1];
                            fl_reg[i] <= fl_reg[i+1];
                        end
                    end
                    fcnt_reg <= fcnt_reg - CW'(1);
                    // Push grant onto held list.
                    for (int i = 1; i < MAX_SEGMENTS; i++) begin
                        hs_reg[i] <= hs_reg[i-1];
                        hl_reg[i] <= hl_reg[i-1];
                    end
                    hs_reg[0] <= fs_reg[pick_reg];
                    hl_reg[0] <= size_reg;
                    hcnt_reg  <= hcnt_reg + CW'(1);
                    total_reg <= total_reg + size_reg;
                    phase_reg <= MV_PUSH;
                end else begin
                    for (int i = 0; i < MAX_SEGMENTS - 1; i++) begin
                        if (i >= int'(pick_reg)) begin
                            hs_reg[i] <= hs_reg[i+1];
                            hl_reg[i] <= hl_reg[i+1];
                        end
                    end
                    hcnt_reg  <= hcnt_reg - CW'(1);
                    total_reg <= total_reg - hl_reg[pick_reg];
                    for (int i = 1; i < MAX_SEGMENTS; i++) begin
                        fs_reg[i] <= fs_reg[i-1];
                        fl_reg[i] <= fl_reg[i-1];
                    end
                    fs_reg[0] <= hs_reg[pick_reg];
                    fl_reg[0] <= hl_reg[pick_reg];
                    fcnt_reg  <= fcnt_reg + CW'(1);
                end
            end else if (phase_reg == MV_PUSH) begin
                // Phase 2: push remainder onto free list.
                if (pl_reg > size_reg) begin
                    for (int i = 1; i < MAX_SEGMENTS; i++) begin
                        fs_reg[i] <= fs_reg[i-1];
                        fl_reg[i] <= fl_reg[i-1];
                    end
                    fs_reg[0] <= ps_reg + OFFSET_BITS'(size_reg);
                    fl_reg[0] <= pl_reg - size_reg;
                    fcnt_reg  <= fcnt_reg + CW'(1);
                end
                phase_reg <= MV_IDLE;
            end
        end
    end

    // Result fields, driven out through the top's m_data while the controller offers the result.
    logic [1:0] rstat_reg;
    logic [OFFSET_BITS-1:0] rgrant_reg;
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            rstat_reg  <= ST_OK;
            rgrant_reg <= (func_reg == FUNC_ALLOC) ? fs_reg[pick_reg] : '0;
        end else if (cmd.fail) begin
            rstat_reg  <= cmd.fail_status;
            rgrant_reg <= '0;
        end
    end

    always_comb begin
        rsp.status         = rstat_reg;
        rsp.granted_offset = 16'(rgrant_reg);
        rsp.live_count     = 6'(hcnt_reg);
        rsp.used_units     = total_reg;
        rsp.spare_units    = capacity - total_reg;
    end
endmodule

@@ sv/fsba_ctrl.sv @@
// Controller: sequences load, scan, commit and result handshake.
module fsba_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    input  logic           func,
    input  logic           cfg_init,
    input  fsba_pkg::sts_t sts,
    output fsba_pkg::cmd_t cmd
);
    import fsba_pkg::*;
    `include "fit_strategy_block_allocator_top_defines.svh"

    typedef enum logic [2:0] {S_IDLE, S_CHECK, S_SCAN, S_DECIDE, S_WAIT, S_OUT} state_t;
    state_t state_reg;
    logic   func_reg;

    assign s_ready = state_reg == S_IDLE && !cfg_init;
    assign m_valid = state_reg == S_OUT;

    always_comb begin
        cmd = '0;
        cmd.init = cfg_init;
        case (state_reg)
            S_IDLE:  cmd.load = s_valid && s_ready;
            S_CHECK: begin
                if (func_reg == FUNC_ALLOC && sts.size_zero) begin
                    cmd.fail = 1'b1; cmd.fail_status = ST_NO_FIT;
                end else if (func_reg == FUNC_ALLOC && sts.held_full) begin
                    cmd.fail = 1'b1; cmd.fail_status = ST_FULL;
                end
            end
            S_SCAN:  cmd.scan = 1'b1;
            S_DECIDE: begin
                if (!sts.found) begin
                    cmd.fail = 1'b1;
                    cmd.fail_status = (func_reg == FUNC_ALLOC) ? ST_NO_FIT : ST_NOT_FND;
                end else if (func_reg == FUNC_FREE && sts.free_full) begin
                    cmd.fail = 1'b1; cmd.fail_status = ST_FULL;
                end else begin
                    cmd.commit = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            func_reg  <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: if (s_valid && s_ready) begin
                    func_reg  <= func;
                    state_reg <= S_CHECK;
                end
                S_CHECK:  state_reg <= cmd.fail ? S_OUT : S_SCAN;
                S_SCAN:   if (sts.scan_done) state_reg <= S_DECIDE;
                S_DECIDE: state_reg <= cmd.commit ? S_WAIT : S_OUT;
                S_WAIT:   if (!sts.busy_move) state_reg <= S_OUT;
                S_OUT:    if (m_ready) state_reg <= S_IDLE;
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

    `FSBA_ASSERT_IMPL(a_one_cmd, aclk, aresetn, 1'b1,
        $countones({cmd.load, cmd.scan, cmd.commit, cmd.fail}) <= 1, "cmd overlap")
    `FSBA_ASSERT_NEXT(a_commit_waits, aclk, aresetn, cmd.commit, state_reg == S_WAIT,
        "commit did not enter update")
    `FSBA_ASSERT_IMPL(a_out_after, aclk, aresetn, $rose(m_valid),
        $past(state_reg) == S_CHECK || $past(state_reg) == S_DECIDE ||
        $past(state_reg) == S_WAIT, "result from wrong state")
endmodule

@@ sv/fit_strategy_block_allocator_top.sv @@
// Top level: fit-strategy allocator with config registers and handshakes.
//
//  channel | ports                                  | moves
//  s_      | s_valid s_ready s_data                 | request transaction
//  m_      | m_valid m_ready m_data                 | result transaction
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data | register write
//
// A request passes the check, scan, decide and update states before its result is
// offered. The scan walks at most MAX_SEGMENTS list entries, one at a time; first fit,
// code 3 and free stop at the hit. An allocation removes the picked entry and pushes
// the grant, then any remainder; a free moves its entry back at once. A refused request
// skips the update; a zero-size or held-table-full allocation goes from the check to
// the result. Reset is synchronous active low; the pool is one free segment of 65535
// units. A stalled result holds the block; a new request is taken only back in idle.
module fit_strategy_block_allocator_top #(
    parameter int MAX_SEGMENTS = 32,
    parameter int OFFSET_BITS  = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  fsba_pkg::req_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output fsba_pkg::rsp_t  m_data,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic            cfg_index,
    input  logic [15:0]     cfg_data
);
    import fsba_pkg::*;

    logic [1:0]  strategy_reg;
    logic [15:0] capacity_reg;
    logic        init_reg;
    cmd_t        cmd;
    sts_t        sts;

    // Config is always ready; a pool write reinitialises lists next cycle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strategy_reg <= STRAT_FIRST;
            capacity_reg <= 16'hFFFF;
            init_reg     <= 1'b0;
        end else begin
            init_reg <= 1'b0;
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_STRATEGY: strategy_reg <= cfg_data[1:0];
                    CFG_CAPACITY: begin
                        capacity_reg <= cfg_data;
                        init_reg     <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    fsba_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready),
        .func(s_data.func), .cfg_init(init_reg),
        .sts(sts), .cmd(cmd)
    );

    fsba_datapath #(.MAX_SEGMENTS(MAX_SEGMENTS), .OFFSET_BITS(OFFSET_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cmd(cmd), .sts(sts), .req(s_data),
        .strategy(strategy_reg), .capacity(capacity_reg),
        .rsp(m_data)
    );
endmodule

@@ tb/sv/tb_fit_strategy_block_allocator_top.sv @@
// Self-checking testbench for the fit-strategy allocator: directed and random requests.
module tb_fit_strategy_block_allocator_top;
    timeunit 1ns;
    timeprecision 1ps;
    import fsba_pkg::*;

    localparam int           SEG_MAX     = 32;
    localparam logic [1:0]   STRAT_CODE3 = 2'd3;   // unused code, behaves as first fit

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    req_t        s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    rsp_t        m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_STRATEGY;
    logic [15:0] cfg_data  = '0;

    fit_strategy_block_allocator_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Mirror of the allocator state: free and held segment lists, head at entry 0.
    logic [15:0] free_start [SEG_MAX];
    logic [15:0] free_len   [SEG_MAX];
    int          free_cnt;
    logic [15:0] held_start [SEG_MAX];
    logic [15:0] held_len   [SEG_MAX];
    int          held_cnt;
    logic [15:0] held_sum;
    logic [15:0] pool_units;
    logic [1:0]  fit_rule;

    rsp_t        pending_rsp[$];   // expected result transactions, oldest first
    int          err_cnt   = 0;
    int          idle_pct  = 0;    // sender idle chance per cycle
    int          stall_pct = 0;    // receiver stall chance per cycle

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #60ms;
        $display("FAIL");
        $finish;
    end

    // Randomize receiver back-pressure every cycle.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Compare each result transaction against the oldest expectation.
    always @(posedge aclk) begin
        rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_rsp.size() == 0) begin
                $error("unexpected result transaction %h", m_data);
                err_cnt++;
            end else begin
                want = pending_rsp.pop_front();
                if (m_data.status !== want.status) begin
                    $error("status exp %0d got %0d", want.status, m_data.status);
                    err_cnt++;
                end
                if (m_data.granted_offset !== want.granted_offset) begin
                    $error("granted_offset exp %0d got %0d", want.granted_offset,
                           m_data.granted_offset);
                    err_cnt++;
                end
                if (m_data.live_count !== want.live_count) begin
                    $error("live_count exp %0d got %0d", want.live_count, m_data.live_count);
                    err_cnt++;
                end
                if (m_data.used_units !== want.used_units) begin
                    $error("used_units exp %0d got %0d", want.used_units, m_data.used_units);
                    err_cnt++;
                end
                if (m_data.spare_units !== want.spare_units) begin
                    $error("spare_units exp %0d got %0d", want.spare_units,
                           m_data.spare_units);
                    err_cnt++;
                end
            end
        end
    end

    function automatic void clear_lists();
        free_start[0] = '0;
        free_len[0]   = pool_units;
        free_cnt      = 1;
        held_cnt      = 0;
        held_sum      = '0;
    endfunction

    // Insert at the head of the free list.
    function automatic void free_push(logic [15:0] s, logic [15:0] l);
        for (int k = free_cnt; k > 0; k--) begin
            free_start[k] = free_start[k-1];
            free_len[k]   = free_len[k-1];
        end
        free_start[0] = s;
        free_len[0]   = l;
        free_cnt++;
    endfunction

    function automatic void free_drop(int idx);
        for (int k = idx; k < free_cnt - 1; k++) begin
            free_start[k] = free_start[k+1];
            free_len[k]   = free_len[k+1];
        end
        free_cnt--;
    endfunction

    // Work out the result of one request and advance the mirrored lists.
    function automatic rsp_t allocator_result(req_t r);
        rsp_t        res;
        int          pick;
        int          hit;
        logic [15:0] seg_s;
        logic [15:0] seg_l;
        res = '0;
        res.status = ST_OK;
        if (r.func == FUNC_ALLOC) begin
            if (r.req_size == 0) begin
                res.status = ST_NO_FIT;
            end else if (held_cnt >= SEG_MAX) begin
                res.status = ST_FULL;
            end else begin
                pick = -1;
                for (int i = 0; i < free_cnt; i++) begin
                    if (free_len[i] >= r.req_size) begin
                        if (fit_rule == STRAT_BEST) begin
                            if (pick < 0 || free_len[i] < free_len[pick]) pick = i;
                        end else if (fit_rule == STRAT_WORST) begin
                            if (pick < 0 || free_len[i] > free_len[pick]) pick = i;
                        end else begin
                            pick = i;
                            break;
                        end
                    end
                end
                if (pick < 0) begin
                    res.status = ST_NO_FIT;
                end else begin
                    seg_s = free_start[pick];
                    seg_l = free_len[pick];
                    free_drop(pick);
                    for (int k = held_cnt; k > 0; k--) begin
                        held_start[k] = held_start[k-1];
                        held_len[k]   = held_len[k-1];
                    end
                    held_start[0] = seg_s;
                    held_len[0]   = r.req_size;
                    held_cnt++;
                    held_sum = held_sum + r.req_size;
                    if (seg_l > r.req_size) free_push(seg_s + r.req_size, seg_l - r.req_size);
                    res.granted_offset = seg_s;
                end
            end
        end else begin
            hit = -1;
            for (int i = 0; i < held_cnt; i++) begin
                if (held_start[i] == r.release_offset) begin
                    hit = i;
                    break;
                end
            end
            if (hit < 0) begin
                res.status = ST_NOT_FND;
            end else if (free_cnt >= SEG_MAX) begin
                res.status = ST_FULL;
            end else begin
                seg_s = held_start[hit];
                seg_l = held_len[hit];
                for (int k = hit; k < held_cnt - 1; k++) begin
                    held_start[k] = held_start[k+1];
                    held_len[k]   = held_len[k+1];
                end
                held_cnt--;
                held_sum = held_sum - seg_l;
                free_push(seg_s, seg_l);
            end
        end
        res.live_count  = held_cnt[5:0];
        res.used_units  = held_sum;
        res.spare_units = pool_units - held_sum;
        return res;
    endfunction

    // Send one request; valid stays high afterwards unless the next call idles.
    task automatic send_req(logic f, logic [15:0] sz, logic [15:0] off);
        req_t r;
        r.func           = f;
        r.req_size       = sz;
        r.release_offset = off;
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_rsp.push_back(allocator_result(r));
    endtask

    // Hold off requests until every expected result has come back.
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_STRATEGY) begin
            fit_rule = val[1:0];
        end else begin
            pool_units = val;
            clear_lists();
        end
    endtask

    // Whole pool in one grant, then overflow, a bad offset, its release, zero size and a double free.
    task automatic test_field_extremes();
        send_req(FUNC_ALLOC, 16'hFFFF, 16'hFFFF);
        send_req(FUNC_ALLOC, 16'd1, 16'd0);
        send_req(FUNC_FREE, 16'hFFFF, 16'hFFFF);
        send_req(FUNC_FREE, 16'd0, 16'd0);
        send_req(FUNC_ALLOC, 16'd0, 16'd0);
        send_req(FUNC_FREE, 16'd0, 16'd0);
    endtask

    // Pool of zero refuses every allocation; pool of one fits exactly once.
    task automatic test_pool_extremes();
        write_reg(CFG_CAPACITY, 16'd0);
        send_req(FUNC_ALLOC, 16'd1, 16'd0);
        send_req(FUNC_ALLOC, 16'd0, 16'd0);
        write_reg(CFG_CAPACITY, 16'd1);
        send_req(FUNC_ALLOC, 16'd1, 16'd0);
        send_req(FUNC_ALLOC, 16'd1, 16'd0);
        send_req(FUNC_FREE, 16'd0, 16'd0);
    endtask

    // Build a fragmented free list, then place under each rule.
    task automatic test_fit_rules();
        logic [1:0] rules[4];
        rules = '{STRAT_FIRST, STRAT_BEST, STRAT_WORST, STRAT_CODE3};
        foreach (rules[n]) begin
            write_reg(CFG_CAPACITY, 16'd100);
            write_reg(CFG_STRATEGY, rules[n]);
            send_req(FUNC_ALLOC, 16'd10, 16'd0);
            send_req(FUNC_ALLOC, 16'd30, 16'd0);
            send_req(FUNC_ALLOC, 16'd20, 16'd0);
            send_req(FUNC_FREE, 16'd0, 16'd0);
            send_req(FUNC_FREE, 16'd0, 16'd10);
            send_req(FUNC_ALLOC, 16'd8, 16'd0);
            send_req(FUNC_ALLOC, 16'd8, 16'd0);
        end
    endtask

    // Fill the held table, then free everything until the free table fills.
    task automatic test_table_full();
        write_reg(CFG_STRATEGY, STRAT_FIRST);
        write_reg(CFG_CAPACITY, 16'd100);
        for (int i = 0; i < SEG_MAX + 1; i++) send_req(FUNC_ALLOC, 16'd1, 16'd0);
        for (int i = 0; i < SEG_MAX; i++) send_req(FUNC_FREE, 16'd0, i[15:0]);
    endtask

    // Mostly well-formed alloc/free traffic on small pools, some noise.
    task automatic test_random(int n_items);
        int          roll;
        logic [15:0] sz;
        for (int i = 0; i < n_items; i++) begin
            if (i % 150 == 0) begin
                write_reg(CFG_STRATEGY, 16'($urandom_range(3)));
                write_reg(CFG_CAPACITY, ($urandom_range(9) == 0) ? 16'hFFFF
                                                                 : 16'($urandom_range(16, 600)));
            end
            roll = $urandom_range(99);
            if (roll < 45) begin
                sz = (pool_units == 16'hFFFF) ? 16'($urandom_range(1, 4000))
                                              : 16'($urandom_range(1, pool_units / 10 + 1));
                send_req(FUNC_ALLOC, sz, 16'($urandom));
            end else if (roll < 80 && held_cnt > 0) begin
                send_req(FUNC_FREE, 16'($urandom),
                         held_start[$urandom_range(held_cnt - 1)]);
            end else if (roll < 90) begin
                send_req(1'($urandom), 16'($urandom), 16'($urandom));
            end else begin
                send_req(FUNC_ALLOC, ($urandom_range(1) == 0) ? 16'd0 : 16'($urandom), 16'd0);
            end
        end
    endtask

    initial begin
        fit_rule   = STRAT_FIRST;
        pool_units = 16'hFFFF;
        clear_lists();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_field_extremes();
        test_pool_extremes();
        test_fit_rules();
        test_table_full();

        // Idle phases: none, sender idles, receiver stalls, both.
        idle_pct = 0;  stall_pct = 0;  test_random(450);
        idle_pct = 79; stall_pct = 0;  test_random(450);
        idle_pct = 0;  stall_pct = 79; test_random(450);
        idle_pct = 15; stall_pct = 15; test_random(450);

        drain();
        if (err_cnt == 0 && pending_rsp.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ fit_strategy_block_allocator_top.f @@
+incdir+sv
sv/fsba_pkg.sv
sv/fsba_datapath.sv
sv/fsba_ctrl.sv
sv/fit_strategy_block_allocator_top.sv
tb/sv/tb_fit_strategy_block_allocator_top.sv
